// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define VFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define VFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define VFD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// vfd_pkg
// Types, constants and lookup tables of the VFD display RAM composer.
// ----------------------------------------------------------------------------
package vfd_pkg;

   localparam int RAM_BYTES  = 48;
   localparam int DIGIT_BASE = 3;
   localparam int ROW_BYTES  = 3;
   localparam int ROWS       = RAM_BYTES / ROW_BYTES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ROW_BITS   = 8 * ROW_BYTES;

   localparam logic [2:0] CMD_DIGIT   = 3'd0;
   localparam logic [2:0] CMD_SYMBOL  = 3'd1;
   localparam logic [2:0] CMD_DOTS    = 3'd2;
   localparam logic [2:0] CMD_BAR     = 3'd3;
   localparam logic [2:0] CMD_REFRESH = 3'd4;
   localparam logic [2:0] CMD_INIT    = 3'd5;

   localparam logic [7:0] BYTE_HEAD  = 8'hC0;
   localparam logic [7:0] BYTE_TAIL  = 8'h8F;
   localparam logic [7:0] BYTE_INIT0 = 8'h0F;
   localparam logic [7:0] BYTE_INIT2 = 8'h40;

   localparam logic [ROW_W-1:0] ROW_SYM_LOW  = ROW_W'(0);
   localparam logic [ROW_W-1:0] ROW_SYM_HIGH = ROW_W'(13);
   localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);

   localparam logic [ROW_BITS-1:0] DOT_CLEAR = 24'h0FF800;
   localparam logic [ROW_BITS-1:0] DOT_PAT0  = 24'h007800;
   localparam logic [ROW_BITS-1:0] DOT_PAT1  = 24'h0AD000;
   localparam logic [ROW_BITS-1:0] DOT_PAT2  = 24'h01B200;
   localparam logic [ROW_BITS-1:0] DOT_PAT3  = 24'h0FF800;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_UPDATE  = 2'd1,
      KIND_REFRESH = 2'd2,
      KIND_INIT    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SEL_HEAD  = 3'd0,
      SEL_RAM   = 3'd1,
      SEL_TAIL  = 3'd2,
      SEL_INIT0 = 3'd3,
      SEL_INIT2 = 3'd4
   } out_sel_type;

   typedef struct packed {
      logic              req_load;
      logic              mem_rd;
      logic              mem_wr;
      logic [ROW_W-1:0]  rd_row;
      logic              out_load;
      out_sel_type       out_sel;
      logic [1:0]        byte_sel;
      logic              eot;
      logic              last;
   } ctl_type;

   typedef struct packed {
      kind_type          kind;
      logic [ROW_W-1:0]  target_row;
      logic              out_free;
   } sts_type;

   function automatic logic [ROW_BITS-1:0] seg_entry(input logic [5:0] k);
      logic [ROW_BITS-1:0] code;
      case (k)
         6'd0:  code = 24'hf111f0;
         6'd1:  code = 24'h210110;
         6'd2:  code = 24'h61f0e0;
         6'd3:  code = 24'h61e170;
         6'd4:  code = 24'hb1e110;
         6'd5:  code = 24'hd0e170;
         6'd6:  code = 24'hd0f1f0;
         6'd7:  code = 24'h610110;
         6'd8:  code = 24'hf1f1f0;
         6'd9:  code = 24'hf1e170;
         6'd10: code = 24'h51f190;
         6'd11: code = 24'hd1f1e0;
         6'd12: code = 24'hf010f0;
         6'd13: code = 24'hd111e0;
         6'd14: code = 24'hf0f0f0;
         6'd15: code = 24'hf0f080;
         6'd16: code = 24'hf031e0;
         6'd17: code = 24'hb1f190;
         6'd18: code = 24'h444460;
         6'd19: code = 24'h2101f0;
         6'd20: code = 24'hb2d290;
         6'd21: code = 24'h9010f0;
         6'd22: code = 24'hbb5190;
         6'd23: code = 24'hb35990;
         6'd24: code = 24'h511160;
         6'd25: code = 24'h51f080;
         6'd26: code = 24'h511370;
         6'd27: code = 24'h51f290;
         6'd28: code = 24'h70e1e0;
         6'd29: code = 24'he44420;
         6'd30: code = 24'hb11160;
         6'd31: code = 24'hb25880;
         6'd32: code = 24'hb15b90;
         6'd33: code = 24'haa4a90;
         6'd34: code = 24'haa4420;
         6'd35: code = 24'he248f0;
         default: code = '0;
      endcase
      return code;
   endfunction

   // Lowercase letters share the uppercase codes; anything else blanks the digit.
   function automatic logic [ROW_BITS-1:0] char_code(input logic [7:0] ch);
      logic [ROW_BITS-1:0] code;
      code = '0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         code = seg_entry(6'(ch - 8'h30));
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         code = seg_entry(6'(ch - 8'h41) + 6'd10);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         code = seg_entry(6'(ch - 8'h61) + 6'd10);
      end
      return code;
   endfunction

   function automatic logic [ROW_W-1:0] bar_row(input logic [3:0] col);
      logic [ROW_W-1:0] row;
      if (col >= 4'd9)      row = ROW_W'(15);
      else if (col >= 4'd6) row = ROW_W'(14);
      else if (col >= 4'd3) row = ROW_W'(12);
      else                  row = ROW_W'(11);
      return row;
   endfunction

   function automatic logic [4:0] bar_bit_pos(input logic [3:0] col);
      logic [4:0] pos;
      case (col)
         4'd0, 4'd3, 4'd8, 4'd11: pos = 5'd4;
         4'd1, 4'd4, 4'd7, 4'd10: pos = 5'd3;
         default:                 pos = 5'd2;
      endcase
      return pos;
   endfunction

endpackage

// ===== rtl/vfd_datapath.sv =====
// ----------------------------------------------------------------------------
// vfd_datapath
// Display RAM as 16 rows of 3 bytes, request registers, row update logic and
// the output register.
// ----------------------------------------------------------------------------
module vfd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_cmd,
   input  logic [5:0]             req_item_index,
   input  logic [7:0]             req_item_value,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_end_of_transfer,
   output logic                   rsp_last,
   input  vfd_pkg::ctl_type       ctl,
   output vfd_pkg::sts_type       sts
);

   logic [vfd_pkg::ROW_BITS-1:0] mem [vfd_pkg::ROWS];
   logic [vfd_pkg::ROWS-1:0]     row_vld_ff;
   logic [vfd_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic [2:0]                   cmd_ff;
   logic [5:0]                   idx_ff;
   logic [7:0]                   val_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   byte_ff;
   logic                         eot_ff;
   logic                         last_ff;

   logic [vfd_pkg::ROW_BITS-1:0] old_row;
   logic [vfd_pkg::ROW_BITS-1:0] new_row;
   logic [5:0]                   sym_t;
   logic [4:0]                   sym_pos;
   logic [4:0]                   bar_base;
   logic [4:0]                   cell_pos;
   logic [3:0]                   level;
   logic [7:0]                   ram_byte;
   logic [7:0]                   byte_in;

   // Rows never written since reset read as zero.
   assign old_row = rd_vld_ff ? rd_data_ff : '0;
   assign sym_t   = idx_ff - 6'd7;
   assign level   = val_ff[3:0];
   assign bar_base = vfd_pkg::bar_bit_pos(idx_ff[3:0]);

   always_comb begin
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.kind       = vfd_pkg::KIND_NONE;
      sts.target_row = vfd_pkg::ROW_SYM_LOW;
      case (cmd_ff)
         vfd_pkg::CMD_DIGIT: begin
            if (idx_ff <= 6'd9) begin
               sts.kind       = vfd_pkg::KIND_UPDATE;
               sts.target_row = vfd_pkg::ROW_W'(idx_ff) + vfd_pkg::ROW_W'(1);
            end
         end
         vfd_pkg::CMD_SYMBOL: begin
            if (idx_ff <= 6'd46) begin
               sts.kind = vfd_pkg::KIND_UPDATE;
               if (idx_ff >= 6'd7 && sym_t[5:3] >= 3'd2) begin
                  sts.target_row = vfd_pkg::ROW_SYM_HIGH;
               end
            end
         end
         vfd_pkg::CMD_DOTS: begin
            sts.kind = vfd_pkg::KIND_UPDATE;
         end
         vfd_pkg::CMD_BAR: begin
            if (idx_ff <= 6'd11 && val_ff <= 8'd8) begin
               sts.kind       = vfd_pkg::KIND_UPDATE;
               sts.target_row = vfd_pkg::bar_row(idx_ff[3:0]);
            end
         end
         vfd_pkg::CMD_REFRESH: sts.kind = vfd_pkg::KIND_REFRESH;
         vfd_pkg::CMD_INIT:    sts.kind = vfd_pkg::KIND_INIT;
         default:              sts.kind = vfd_pkg::KIND_NONE;
      endcase
   end

   // Symbols 0..6 sit above bit 0 of byte 0; the rest fill whole bytes.
   always_comb begin
      if (idx_ff < 6'd7) begin
         sym_pos = 5'(idx_ff) + 5'd1;
      end else begin
         case (sym_t[5:3])
            3'd0, 3'd3: sym_pos = 5'd8 + 5'(sym_t[2:0]);
            3'd1, 3'd4: sym_pos = 5'd16 + 5'(sym_t[2:0]);
            default:    sym_pos = 5'(sym_t[2:0]);
         endcase
      end
   end

   always_comb begin
      new_row  = old_row;
      cell_pos = '0;
      case (cmd_ff)
         vfd_pkg::CMD_DIGIT: new_row = vfd_pkg::char_code(val_ff);
         vfd_pkg::CMD_SYMBOL: begin
            if (val_ff != 8'd0) begin
               new_row = old_row | (24'd1 << sym_pos);
            end else begin
               new_row = old_row & ~(24'd1 << sym_pos);
            end
         end
         vfd_pkg::CMD_DOTS: begin
            new_row = old_row & ~vfd_pkg::DOT_CLEAR;
            case (val_ff)
               8'd0:    new_row = new_row | vfd_pkg::DOT_PAT0;
               8'd1:    new_row = new_row | vfd_pkg::DOT_PAT1;
               8'd2:    new_row = new_row | vfd_pkg::DOT_PAT2;
               8'd3:    new_row = new_row | vfd_pkg::DOT_PAT3;
               default: new_row = new_row;
            endcase
         end
         vfd_pkg::CMD_BAR: begin
            // The marker sits in bit 7 of the row's top byte, above all cells.
            if (level != 4'd0) begin
               new_row[23] = 1'b1;
            end
            for (int i = 0; i < 7; i++) begin
               cell_pos = bar_base + 5'(3 * i);
               new_row[cell_pos] = (level > 4'd1) && ((4'(i) + level) >= 4'd8);
            end
         end
         default: new_row = old_row;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[sts.target_row] <= new_row;
      end
      if (ctl.mem_rd) begin
         rd_data_ff <= mem[ctl.rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (ctl.mem_wr) begin
            row_vld_ff[sts.target_row] <= 1'b1;
         end
         if (ctl.mem_rd) begin
            rd_vld_ff <= row_vld_ff[ctl.rd_row];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_item_index;
         val_ff <= req_item_value;
      end
   end

   always_comb begin
      case (ctl.byte_sel)
         2'd0:    ram_byte = old_row[7:0];
         2'd1:    ram_byte = old_row[15:8];
         default: ram_byte = old_row[23:16];
      endcase
      case (ctl.out_sel)
         vfd_pkg::SEL_HEAD:  byte_in = vfd_pkg::BYTE_HEAD;
         vfd_pkg::SEL_RAM:   byte_in = ram_byte;
         vfd_pkg::SEL_TAIL:  byte_in = vfd_pkg::BYTE_TAIL;
         vfd_pkg::SEL_INIT0: byte_in = vfd_pkg::BYTE_INIT0;
         vfd_pkg::SEL_INIT2: byte_in = vfd_pkg::BYTE_INIT2;
         default:            byte_in = vfd_pkg::BYTE_HEAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         byte_ff <= byte_in;
         eot_ff  <= ctl.eot;
         last_ff <= ctl.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_end_of_transfer = eot_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== rtl/vfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfd_ctrl
// Sequencer: accepts commands, runs row read-modify-write for updates and
// walks the byte streams for refresh and init.
// ----------------------------------------------------------------------------
module vfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vfd_pkg::sts_type       sts,
   output vfd_pkg::ctl_type       ctl
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_MODIFY = 7'b0000100,
      ST_HEAD   = 7'b0001000,
      ST_FETCH  = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_TAIL   = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [vfd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [1:0]                  byte_ff, byte_in;
   logic                        init_ff, init_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      byte_in      = byte_ff;
      init_in      = init_ff;
      ctl          = '0;
      ctl.out_sel  = vfd_pkg::SEL_HEAD;
      ctl.rd_row   = sts.target_row;
      ctl.byte_sel = byte_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.req_load = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            row_in  = '0;
            byte_in = '0;
            case (sts.kind)
               vfd_pkg::KIND_UPDATE: begin
                  ctl.mem_rd = 1'b1;
                  state_in   = ST_MODIFY;
               end
               vfd_pkg::KIND_REFRESH: begin
                  init_in  = 1'b0;
                  state_in = ST_HEAD;
               end
               vfd_pkg::KIND_INIT: begin
                  init_in  = 1'b1;
                  state_in = ST_EMIT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MODIFY: begin
            ctl.mem_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_HEAD: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_sel  = vfd_pkg::SEL_HEAD;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_row = row_ff;
            byte_in    = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               if (init_ff) begin
                  // The init sequence reuses the byte counter.
                  if (byte_ff == 2'd2) begin
                     ctl.out_sel = vfd_pkg::SEL_INIT2;
                     ctl.eot     = 1'b1;
                     ctl.last    = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     ctl.out_sel = vfd_pkg::SEL_INIT0;
                     byte_in     = byte_ff + 2'd1;
                  end
               end else begin
                  ctl.out_sel = vfd_pkg::SEL_RAM;
                  ctl.eot     = (row_ff == vfd_pkg::ROW_LAST) && (byte_ff == 2'd2);
                  if (byte_ff == 2'd2) begin
                     if (row_ff == vfd_pkg::ROW_LAST) begin
                        state_in = ST_TAIL;
                     end else begin
                        row_in   = row_ff + vfd_pkg::ROW_W'(1);
                        state_in = ST_FETCH;
                     end
                  end else begin
                     byte_in = byte_ff + 2'd1;
                  end
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_sel  = vfd_pkg::SEL_TAIL;
               ctl.eot      = 1'b1;
               ctl.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         byte_ff  <= '0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         byte_ff  <= byte_in;
         init_ff  <= init_in;
      end
   end

endmodule

// ===== rtl/vfd_display_ram_composer_top.sv =====
// ----------------------------------------------------------------------------
// vfd_display_ram_composer_top
// Keeps the 48-byte display RAM of a segment VFD driver and streams it out.
// An update command (digit, symbol, dots, bar) is decoded while its 3-byte
// row is read, then the row is written back, and only then is the next
// command accepted. A refresh sends 50 bytes: a head byte, then each of the
// 16 rows is read before its 3 bytes go out, then a tail byte. Init sends 3
// bytes. Invalid commands give nothing.
// ----------------------------------------------------------------------------
module vfd_display_ram_composer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [5:0] req_item_index,
   input  logic [7:0] req_item_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_transfer,
   output logic       rsp_last
);

   vfd_pkg::ctl_type ctl;
   vfd_pkg::sts_type sts;

   vfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   vfd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_item_index      (req_item_index),
      .req_item_value      (req_item_value),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_last            (rsp_last),
      .ctl                 (ctl),
      .sts                 (sts)
   );

endmodule

// ===== rtl/vfd_checker.sv =====
// ----------------------------------------------------------------------------
// vfd_checker
// Port-level checks of the composer's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_transfer,
   input logic       rsp_last
);

   logic end_byte;

   assign end_byte = (rsp_out_byte == vfd_pkg::BYTE_TAIL) ||
                     (rsp_out_byte == vfd_pkg::BYTE_INIT2);

   // A stalled transaction stays on the port.
   `VFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // The final byte of a command always closes a chip-select transaction.
   `VFD_ASSERT_NOW(a_last_eot, clock, reset, rsp_valid && rsp_last, rsp_end_of_transfer)
   // Commands end only with the refresh tail byte or the init data byte.
   `VFD_ASSERT_NOW(a_last_byte, clock, reset, rsp_valid && rsp_last, end_byte)
   // Reset empties the output register.
   `VFD_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind vfd_display_ram_composer_top vfd_checker u_vfd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_end_of_transfer (rsp_end_of_transfer),
   .rsp_last            (rsp_last)
);
